>>> rtl/tkft_pkg.sv
// Shared types and constants for the top-k frequency tracker.
`default_nettype none

package tkft_pkg;

  localparam int unsigned TOP_ENTRIES = 10;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned KEY_W       = 32;

  // Count sits above key, so a plain unsigned compare of the whole word
  // gives the lexicographic (count, key) order.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   key;
  } pair_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    logic  en;
    pair_t data;
  } wr_req_t;

endpackage

`default_nettype wire

>>> rtl/tkft_pair_cmp.sv
// Shared (count, key) pair comparator.
`default_nettype none

module tkft_pair_cmp (
  input  wire tkft_pkg::pair_t a,
  input  wire tkft_pkg::pair_t b,
  output tkft_pkg::cmp_res_t   res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

`default_nettype wire

>>> rtl/tkft_table.sv
// Kept-pair table: one write port, one registered read port.
`default_nettype none

module tkft_table #(
  parameter int unsigned DEPTH  = tkft_pkg::TOP_ENTRIES,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire tkft_pkg::wr_req_t wr_req,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output tkft_pkg::pair_t        rd_data
);

  tkft_pkg::pair_t mem [DEPTH];
  tkft_pkg::pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/top_k_frequency_tracker_core.sv
// Top level of the top-k frequency tracker: sequencer, table and comparator.
//
// Keeps the TOP_ENTRIES largest (count, key) pairs, count compared first.
// One request is taken at a time; in_ready is high only while the block is
// idle. A request that is appended to a table still filling, or dropped by a
// full table, passes through ST_INSERT alone. A request that replaces the
// minimum of a full table also passes through ST_SCAN, where the new minimum
// is found by streaming every slot through the single read port of the
// table into one shared comparator. A request flagged last then emits every
// kept entry in slot order, each read in ST_EMIT_RD and held in ST_EMIT_OUT
// until taken; the table is empty afterwards. No clearing pass after reset.
`default_nettype none

module top_k_frequency_tracker_core #(
  parameter int unsigned TOP_ENTRIES = tkft_pkg::TOP_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_item_count,
  input  wire logic [31:0] in_item_key,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_entry_count,
  output logic [31:0]      out_entry_key,
  output logic             out_last_entry
);

  localparam int unsigned SLOT_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TOP_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TOP_ENTRIES);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_INSERT   = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_OUT = 5'b10000
  } state_t;

  state_t              state_r,    state_nxt;
  tkft_pkg::pair_t     item_r,     item_nxt;
  logic                last_r,     last_nxt;
  logic [FILL_W-1:0]   fill_r,     fill_nxt;
  logic [SLOT_W-1:0]   min_slot_r, min_slot_nxt;
  tkft_pkg::pair_t     min_r,      min_nxt;
  logic [FILL_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]   emit_idx_r, emit_idx_nxt;

  tkft_pkg::pair_t     rd_data;
  tkft_pkg::pair_t     cmp_a;
  tkft_pkg::cmp_res_t  cmp_res;
  tkft_pkg::wr_req_t   wr_req;
  logic [SLOT_W-1:0]   wr_addr;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                full;
  logic                item_gt_min;
  logic [SLOT_W-1:0]   chk_slot;
  logic                emit_last;

  assign full        = (fill_r == FILL_FULL);
  assign item_gt_min = !cmp_res.lt && !cmp_res.eq;
  // Slot whose read data arrives this cycle during the rescan.
  assign chk_slot    = SLOT_W'(scan_idx_r - FILL_ONE);
  assign emit_last   = ((FILL_W'(emit_idx_r) + FILL_ONE) == fill_r);

  assign cmp_a = (state_r == ST_SCAN) ? rd_data : item_r;

  tkft_pair_cmp u_cmp (
    .a   (cmp_a),
    .b   (min_r),
    .res (cmp_res)
  );

  assign wr_req.en   = (state_r == ST_INSERT) && (!full || item_gt_min);
  assign wr_req.data = item_r;
  assign wr_addr     = full ? min_slot_r : fill_r[SLOT_W-1:0];

  assign rd_en   = ((state_r == ST_SCAN) && (scan_idx_r != FILL_FULL)) ||
                   (state_r == ST_EMIT_RD);
  assign rd_addr = (state_r == ST_SCAN) ? scan_idx_r[SLOT_W-1:0] : emit_idx_r;

  tkft_table #(
    .DEPTH  (TOP_ENTRIES),
    .ADDR_W (SLOT_W)
  ) u_table (
    .clk     (clk),
    .wr_req  (wr_req),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    last_nxt     = last_r;
    fill_nxt     = fill_r;
    min_slot_nxt = min_slot_r;
    min_nxt      = min_r;
    scan_idx_nxt = scan_idx_r;
    emit_idx_nxt = emit_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt.count = in_item_count;
          item_nxt.key   = in_item_key;
          last_nxt       = in_last_item;
          state_nxt      = ST_INSERT;
        end
      end
      ST_INSERT: begin
        emit_idx_nxt = '0;
        if (!full) begin
          // Append; the first entry always becomes the minimum.
          fill_nxt = fill_r + FILL_ONE;
          if ((fill_r == '0) || cmp_res.lt) begin
            min_slot_nxt = fill_r[SLOT_W-1:0];
            min_nxt      = item_r;
          end
          state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        end else if (item_gt_min) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Take slot 0 as the first candidate; later slots win only when smaller.
        if (scan_idx_r != '0) begin
          if ((scan_idx_r == FILL_ONE) || cmp_res.lt) begin
            min_nxt      = rd_data;
            min_slot_nxt = chk_slot;
          end
        end
        if (scan_idx_r == FILL_FULL) begin
          emit_idx_nxt = '0;
          state_nxt    = last_r ? ST_EMIT_RD : ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + FILL_ONE;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready) begin
          if (emit_last) begin
            fill_nxt     = '0;
            min_slot_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + SLOT_W'(1);
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      min_slot_r <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      min_slot_r <= min_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    last_r     <= last_nxt;
    min_r      <= min_nxt;
    scan_idx_r <= scan_idx_nxt;
    emit_idx_r <= emit_idx_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT_OUT);
  assign out_entry_count = rd_data.count;
  assign out_entry_key   = rd_data.key;
  assign out_last_entry  = emit_last;

endmodule

`default_nettype wire

>>> rtl/tkft_checker.sv
// Port-level checks for the top-k frequency tracker, bound to the top level.
`default_nettype none

module tkft_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last_item,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_entry_count,
  input wire logic [31:0] out_entry_key,
  input wire logic        out_last_entry
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_entry_count) &&
                                   $stable(out_entry_key) && $stable(out_last_entry)))
    else $error("stalled result changed");

  // Never take a request while the table is being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken during emit");

  // A request not flagged last causes no result right after it.
  a_quiet_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last_item) |=> !out_valid)
    else $error("result after non-final request");

  // Drop out of emit after the final entry is taken.
  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_entry) |=> !out_valid)
    else $error("result after final entry");

  // Drop ready in the cycle after a request is taken.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after request");

endmodule

bind top_k_frequency_tracker_core tkft_checker u_tkft_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_item    (in_last_item),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_entry_count (out_entry_count),
  .out_entry_key   (out_entry_key),
  .out_last_entry  (out_last_entry)
);

`default_nettype wire
